### sv/kernel_line_upsampler_defines.svh
// Assertion macros used by the line upsampler top level.
`ifndef KERNEL_LINE_UPSAMPLER_DEFINES_SVH
`define KERNEL_LINE_UPSAMPLER_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define KLU_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define KLU_ASSERT_NEXT(lbl, trig, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) else $error(msg);

`endif

### sv/klu_pkg.sv
// Shared types, constants and register codes of the line upsampler.
package klu_pkg;

    localparam int WINDOW_TAPS     = 5;
    localparam int MAX_LINE_DEF    = 4096;
    localparam int MAX_FACTOR_DEF  = 16;
    localparam int MAX_RESULTS     = 64;

    localparam int PIX_W   = 16;
    localparam int F_W     = 5;
    localparam int KSEL_W  = 2;
    localparam int RECIP_W = 17;
    localparam int CIDX_W  = 2;
    localparam int W_W     = 18;

    // Register indexes of the configuration port.
    localparam logic [CIDX_W-1:0] REG_ZOOM  = 2'd0;
    localparam logic [CIDX_W-1:0] REG_KSEL  = 2'd1;
    localparam logic [CIDX_W-1:0] REG_RECIP = 2'd2;

    // Kernel codes.
    localparam logic [KSEL_W-1:0] KER_BOX   = 2'd0;
    localparam logic [KSEL_W-1:0] KER_TENT  = 2'd1;
    localparam logic [KSEL_W-1:0] KER_QUAD  = 2'd2;
    localparam logic [KSEL_W-1:0] KER_MITCH = 2'd3;

    // Mitchell (B=C=1/3) coefficients in Q14.
    localparam logic [15:0] MIT_K3A = 16'd19115;
    localparam logic [15:0] MIT_K0A = 16'd14564;
    localparam logic [15:0] MIT_K3B = 16'd6372;
    localparam logic [15:0] MIT_K1B = 16'd54613;
    localparam logic [15:0] MIT_K0B = 16'd29127;

    typedef struct packed {
        logic [PIX_W-1:0] sample;
        logic             last_sample;
    } in_word_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last_of_run;
        logic             end_of_line;
    } out_word_t;

    // One kernel tap handed from the sequencer to the weight pipeline.
    typedef struct packed {
        logic              valid;
        logic              first;
        logic              last;
        logic signed [7:0] ofs;
        logic [PIX_W-1:0]  smp;
    } tap_t;

    typedef struct packed {
        logic idle;
        logic pipe_busy;
    } status_t;

endpackage

### sv/klu_queue.sv
// Two-entry command queue between the front and back parts.
module klu_queue #(
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [DW-1:0] push_data,
    output logic          can_push,
    input  logic          pop,
    output logic          has_data,
    output logic [DW-1:0] head
);

    logic [DW-1:0] mem_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;

    assign can_push = (count_reg != 2'd2);
    assign has_data = (count_reg != 2'd0);
    assign head     = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

### sv/klu_front.sv
// Front part: accepts samples, tracks the line position and works out each step's target.
module klu_front #(
    parameter int MAX_LINE   = klu_pkg::MAX_LINE_DEF,
    parameter int MAX_FACTOR = klu_pkg::MAX_FACTOR_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  klu_pkg::in_word_t    in_data,
    input  logic [klu_pkg::F_W-1:0] factor,
    output logic                 push,
    output logic [klu_pkg::PIX_W+2+$clog2(MAX_LINE)+$clog2(MAX_LINE*MAX_FACTOR+1)-1:0]
                                 push_data,
    input  logic                 can_push
);

    localparam int SEEN_W = $clog2(MAX_LINE);
    localparam int TGT_W  = $clog2(MAX_LINE * MAX_FACTOR + 1);

    logic [SEEN_W-1:0]           seen_reg;
    logic [SEEN_W-1:0]           seen_next;
    logic                        last;
    logic                        first;
    logic [TGT_W-1:0]            n_sel;
    logic [TGT_W+klu_pkg::F_W-1:0] prod;
    logic [TGT_W-1:0]            target;

    assign in_ready = can_push;
    assign push     = in_valid && can_push;

    always_comb
    begin
        first = (seen_reg == '0);
        last  = in_data.last_sample || (seen_reg == SEEN_W'(MAX_LINE - 1));
        if (last)
        begin
            n_sel = TGT_W'(seen_reg) + TGT_W'(1);
        end
        else if (first)
        begin
            n_sel = '0;
        end
        else
        begin
            n_sel = TGT_W'(seen_reg) - TGT_W'(1);
        end
        prod      = n_sel * factor;
        target    = prod[TGT_W-1:0];
        seen_next = last ? '0 : seen_reg + SEEN_W'(1);
    end

    assign push_data = {in_data.sample, first, last, seen_reg, target};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
        end
        else if (push)
        begin
            seen_reg <= seen_next;
        end
    end

endmodule

### sv/klu_weight.sv
// Pipelined kernel weight evaluation and five-tap multiply-accumulate.
module klu_weight (
    input  logic                         clk,
    input  logic                         rst_n,
    input  klu_pkg::tap_t                tap,
    input  logic [klu_pkg::KSEL_W-1:0]   kernel_sel,
    input  logic [klu_pkg::RECIP_W-1:0]  recip,
    output logic                         done,
    output logic [klu_pkg::PIX_W-1:0]    pixel,
    output logic                         busy
);

    localparam int PW = klu_pkg::PIX_W;

    // Stage valid, first and last flags.
    logic [5:1] v_reg, f_reg, l_reg;
    logic [PW-1:0] s1_reg, s2_reg, s3_reg, s4_reg;

    logic signed [25:0] x1_reg;

    logic [17:0] a2_reg;
    logic [35:0] aa2_reg;
    logic        box2_reg;

    logic [17:0] a3_reg;
    logic [35:0] aa3_reg;
    logic [21:0] cube3_reg;
    logic [33:0] mm3_reg;
    logic        box3_reg;

    logic signed [klu_pkg::W_W-1:0] w4_reg;
    logic signed [34:0] p5_reg;
    logic signed [39:0] acc_reg;
    logic               done_reg;
    logic [PW-1:0]      pix_reg;

    logic [25:0]  ax;
    logic         in_rng;
    logic [17:0]  a_c;
    logic [37:0]  cube_full;
    logic [16:0]  m_q;
    logic [39:0]  t1, t2, t3;
    logic signed [23:0] w_sel;
    logic signed [39:0] sum;
    logic signed [25:0] sh;

    assign busy  = |v_reg;
    assign done  = done_reg;
    assign pixel = pix_reg;

    always_comb
    begin
        ax     = x1_reg[25] ? 26'(-x1_reg) : 26'(x1_reg);
        in_rng = (ax <= 26'd131072);
        // Arguments beyond every kernel's support saturate so that all kernels give zero.
        a_c    = in_rng ? ax[17:0] : 18'h3FFFF;

        cube_full = aa2_reg[35:16] * a2_reg;
        m_q       = (a2_reg <= 18'd98304) ? 17'(18'd98304 - a2_reg) : 17'd0;

        t1 = (40'(cube3_reg) * 40'(klu_pkg::MIT_K3A)) >> 16;
        t2 = (40'(cube3_reg) * 40'(klu_pkg::MIT_K3B)) >> 16;
        t3 = (40'(a3_reg) * 40'(klu_pkg::MIT_K1B)) >> 16;
        case (kernel_sel)
            klu_pkg::KER_BOX:
            begin
                w_sel = box3_reg ? 24'sd16384 : 24'sd0;
            end
            klu_pkg::KER_TENT:
            begin
                w_sel = (a3_reg <= 18'd65536)
                      ? 24'sd16384 - $signed(24'(a3_reg >> 2)) : 24'sd0;
            end
            klu_pkg::KER_QUAD:
            begin
                if (a3_reg <= 18'd32768)
                begin
                    w_sel = 24'sd12288 - $signed(24'(aa3_reg >> 18));
                end
                else if (a3_reg <= 18'd98304)
                begin
                    w_sel = $signed(24'(mm3_reg >> 19));
                end
                else
                begin
                    w_sel = 24'sd0;
                end
            end
            default:
            begin
                if (a3_reg <= 18'd65536)
                begin
                    w_sel = $signed(24'(t1)) - $signed(24'(aa3_reg >> 17))
                          + $signed(24'(klu_pkg::MIT_K0A));
                end
                else if (a3_reg <= 18'd131072)
                begin
                    w_sel = $signed(24'(aa3_reg >> 17)) - $signed(24'(t2))
                          - $signed(24'(t3)) + $signed(24'(klu_pkg::MIT_K0B));
                end
                else
                begin
                    w_sel = 24'sd0;
                end
            end
        endcase

        sum = (f_reg[5] ? 40'sd0 : acc_reg) + 40'(p5_reg);
        sh  = 26'(sum >>> 14);
    end

    always_ff @(posedge clk)
    begin
        x1_reg   <= 26'(tap.ofs * $signed({1'b0, recip}));
        s1_reg   <= tap.smp;

        a2_reg   <= a_c;
        aa2_reg  <= a_c * a_c;
        box2_reg <= (x1_reg >= -26'sd32768) && (x1_reg < 26'sd32768);
        s2_reg   <= s1_reg;

        a3_reg    <= a2_reg;
        aa3_reg   <= aa2_reg;
        cube3_reg <= cube_full[37:16];
        mm3_reg   <= m_q * m_q;
        box3_reg  <= box2_reg;
        s3_reg    <= s2_reg;

        w4_reg <= klu_pkg::W_W'(w_sel);
        s4_reg <= s3_reg;

        p5_reg <= 35'($signed({1'b0, s4_reg}) * w4_reg);

        if (v_reg[5])
        begin
            acc_reg <= sum;
            if (l_reg[5])
            begin
                if (sum < 0)
                begin
                    pix_reg <= '0;
                end
                else if (sh > 26'sd65535)
                begin
                    pix_reg <= '1;
                end
                else
                begin
                    pix_reg <= sh[PW-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg    <= '0;
            f_reg    <= '0;
            l_reg    <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            v_reg    <= {v_reg[4:1], tap.valid};
            f_reg    <= {f_reg[4:1], tap.first};
            l_reg    <= {l_reg[4:1], tap.last};
            done_reg <= v_reg[5] && l_reg[5];
        end
    end

endmodule

### sv/klu_back.sv
// Back part: holds the window, divides the output index and sequences taps and results.
module klu_back #(
    parameter int MAX_LINE   = klu_pkg::MAX_LINE_DEF,
    parameter int MAX_FACTOR = klu_pkg::MAX_FACTOR_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         has_data,
    input  logic [klu_pkg::PIX_W+2+$clog2(MAX_LINE)+$clog2(MAX_LINE*MAX_FACTOR+1)-1:0]
                                         head,
    output logic                         pop,
    input  logic [klu_pkg::F_W-1:0]      factor,
    input  logic [klu_pkg::KSEL_W-1:0]   kernel_sel,
    input  logic [klu_pkg::RECIP_W-1:0]  recip,
    output logic                         out_valid,
    input  logic                         out_ready,
    output klu_pkg::out_word_t           out_data,
    output klu_pkg::status_t             status
);

    localparam int SEEN_W = $clog2(MAX_LINE);
    localparam int TGT_W  = $clog2(MAX_LINE * MAX_FACTOR + 1);
    localparam int KW     = TGT_W + 2;
    localparam int DC_W   = $clog2(TGT_W);
    localparam int PW     = klu_pkg::PIX_W;
    localparam int FW     = klu_pkg::F_W;
    localparam int NT     = klu_pkg::WINDOW_TAPS;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DIV   = 5'b00010,
        ST_ISSUE = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [PW-1:0]     win_reg [NT];
    logic [SEEN_W-1:0] n_reg;
    logic              last_reg;
    logic [TGT_W-1:0]  target_reg;
    logic [TGT_W-1:0]  idx_reg, idx_next;
    logic [TGT_W-1:0]  c_reg, c_next;
    logic [FW-1:0]     rem_reg, rem_next;
    logic [DC_W-1:0]   dcnt_reg, dcnt_next;
    logic [2:0]        t_reg, t_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic              out_valid_reg;
    klu_pkg::out_word_t out_reg;

    logic [PW-1:0]     h_smp;
    logic              h_first, h_last;
    logic [SEEN_W-1:0] h_n;
    logic [TGT_W-1:0]  h_target;

    logic [FW:0]       div_sh;
    logic              div_ge;
    logic signed [KW-1:0] ks, kc, n_s, pos;
    logic [2:0]        posc;
    logic signed [7:0] tm2, tap_ofs;
    klu_pkg::tap_t     tap;
    logic              w_done, w_busy;
    logic [PW-1:0]     w_pixel;
    logic              fin, out_load;

    assign {h_smp, h_first, h_last, h_n, h_target} = head;

    assign pop = (state_reg == ST_IDLE) && has_data;

    always_comb
    begin
        div_sh = {rem_reg, c_reg[TGT_W-1]};
        div_ge = (div_sh >= {1'b0, factor});

        n_s = $signed(KW'(n_reg));
        ks  = $signed(KW'(c_reg)) + $signed(KW'(t_reg)) - KW'(2);
        if (ks < 0)
        begin
            kc = '0;
        end
        else if (ks > n_s)
        begin
            kc = n_s;
        end
        else
        begin
            kc = ks;
        end
        pos  = n_s - kc;
        posc = (pos > KW'(NT - 1)) ? 3'(NT - 1) : pos[2:0];

        tm2     = $signed({5'b0, t_reg}) - 8'sd2;
        tap_ofs = 8'(tm2 * $signed({3'b0, factor})) - $signed({3'b0, rem_reg});

        tap.valid = (state_reg == ST_ISSUE);
        tap.first = (t_reg == 3'd0);
        tap.last  = (t_reg == 3'(NT - 1));
        tap.ofs   = tap_ofs;
        tap.smp   = win_reg[posc];

        fin = (TGT_W'(idx_reg + TGT_W'(1)) == target_reg)
           || (cnt_reg == 6'(klu_pkg::MAX_RESULTS - 1));
        out_load = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        c_next     = c_reg;
        rem_next   = rem_reg;
        dcnt_next  = dcnt_reg;
        t_next     = t_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (has_data)
                begin
                    if (idx_reg < h_target)
                    begin
                        state_next = ST_DIV;
                        c_next     = idx_reg;
                        rem_next   = '0;
                        dcnt_next  = DC_W'(TGT_W - 1);
                        cnt_next   = '0;
                    end
                    else if (h_last)
                    begin
                        idx_next = '0;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next = div_ge ? FW'(div_sh - {1'b0, factor}) : div_sh[FW-1:0];
                c_next   = {c_reg[TGT_W-2:0], div_ge};
                dcnt_next = dcnt_reg - DC_W'(1);
                if (dcnt_reg == '0)
                begin
                    state_next = ST_ISSUE;
                    t_next     = '0;
                end
            end
            ST_ISSUE:
            begin
                t_next = t_reg + 3'd1;
                if (t_reg == 3'(NT - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (w_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    if (fin)
                    begin
                        state_next = ST_IDLE;
                        idx_next   = last_reg ? '0 : idx_reg + TGT_W'(1);
                    end
                    else
                    begin
                        state_next = ST_ISSUE;
                        t_next     = '0;
                        idx_next   = idx_reg + TGT_W'(1);
                        cnt_next   = cnt_reg + 6'd1;
                        if (rem_reg + FW'(1) == factor)
                        begin
                            rem_next = '0;
                            c_next   = c_reg + TGT_W'(1);
                        end
                        else
                        begin
                            rem_next = rem_reg + FW'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            n_reg      <= h_n;
            last_reg   <= h_last;
            target_reg <= h_target;
            for (int i = 0; i < NT; i++)
            begin
                if (h_first)
                begin
                    win_reg[i] <= h_smp;
                end
                else if (i == 0)
                begin
                    win_reg[i] <= h_smp;
                end
                else
                begin
                    win_reg[i] <= win_reg[i-1];
                end
            end
        end
        c_reg    <= c_next;
        rem_reg  <= rem_next;
        dcnt_reg <= dcnt_next;
        t_reg    <= t_next;
        cnt_reg  <= cnt_next;
        if (out_load)
        begin
            out_reg.pixel       <= w_pixel;
            out_reg.last_of_run <= fin;
            out_reg.end_of_line <= fin && last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    klu_weight u_weight (
        .clk        (clk),
        .rst_n      (rst_n),
        .tap        (tap),
        .kernel_sel (kernel_sel),
        .recip      (recip),
        .done       (w_done),
        .pixel      (w_pixel),
        .busy       (w_busy)
    );

    assign out_valid        = out_valid_reg;
    assign out_data         = out_reg;
    assign status.idle      = (state_reg == ST_IDLE);
    assign status.pipe_busy = w_busy;

endmodule

### sv/kernel_line_upsampler.sv
// Top level of the line upsampler: configuration registers, front, queue and back.
//
//  Channel | Direction | Handshake              | Word
//  in      | in        | in_valid / in_ready    | in_data: sample, last_sample
//  out     | out       | out_valid / out_ready  | out_data: pixel, last_of_run, end_of_line
//  cfg     | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Each output word is made from five taps, issued one per cycle into the six-stage
// weight and multiply-accumulate pipeline, whose result is then loaded for output.
// Each input word that produces output also passes through the serial divider
// that finds the first output's source position and phase.
// Reset clears all control state at once; there is no clearing pass.
// The two-word queue lets samples be taken while the back part works or the output stalls.
module kernel_line_upsampler #(
    parameter int MAX_LINE   = klu_pkg::MAX_LINE_DEF,
    parameter int MAX_FACTOR = klu_pkg::MAX_FACTOR_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  klu_pkg::in_word_t             in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output klu_pkg::out_word_t            out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [klu_pkg::CIDX_W-1:0]    cfg_index,
    input  logic [klu_pkg::RECIP_W-1:0]   cfg_data
);

`include "kernel_line_upsampler_defines.svh"

    localparam int SEEN_W = $clog2(MAX_LINE);
    localparam int TGT_W  = $clog2(MAX_LINE * MAX_FACTOR + 1);
    localparam int DW     = klu_pkg::PIX_W + 2 + SEEN_W + TGT_W;

    logic [klu_pkg::F_W-1:0]     zoom_reg;
    logic [klu_pkg::KSEL_W-1:0]  ksel_reg;
    logic [klu_pkg::RECIP_W-1:0] recip_reg;
    logic [klu_pkg::F_W-1:0]     factor;

    logic          q_push, q_can_push, q_pop, q_has_data;
    logic [DW-1:0] q_push_data, q_head;
    klu_pkg::status_t status;

    // The configuration port never stalls.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zoom_reg  <= klu_pkg::F_W'(1);
            ksel_reg  <= klu_pkg::KER_TENT;
            recip_reg <= klu_pkg::RECIP_W'(65536);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                klu_pkg::REG_ZOOM:  zoom_reg  <= cfg_data[klu_pkg::F_W-1:0];
                klu_pkg::REG_KSEL:  ksel_reg  <= cfg_data[klu_pkg::KSEL_W-1:0];
                klu_pkg::REG_RECIP: recip_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // A factor of zero behaves as one; a factor beyond the limit is clipped to it.
    always_comb
    begin
        if (zoom_reg == '0)
        begin
            factor = klu_pkg::F_W'(1);
        end
        else if (zoom_reg > klu_pkg::F_W'(MAX_FACTOR))
        begin
            factor = klu_pkg::F_W'(MAX_FACTOR);
        end
        else
        begin
            factor = zoom_reg;
        end
    end

    klu_front #(
        .MAX_LINE   (MAX_LINE),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .factor    (factor),
        .push      (q_push),
        .push_data (q_push_data),
        .can_push  (q_can_push)
    );

    klu_queue #(
        .DW (DW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .can_push  (q_can_push),
        .pop       (q_pop),
        .has_data  (q_has_data),
        .head      (q_head)
    );

    klu_back #(
        .MAX_LINE   (MAX_LINE),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .has_data   (q_has_data),
        .head       (q_head),
        .pop        (q_pop),
        .factor     (factor),
        .kernel_sel (ksel_reg),
        .recip      (recip_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .status     (status)
    );

    // The end of a line is always the last word of its step.
    `KLU_ASSERT_ALWAYS(a_eol_is_last, !out_valid || !out_data.end_of_line || out_data.last_of_run, "end_of_line without last_of_run")
    // Between steps no tap may remain in the weight pipeline.
    `KLU_ASSERT_ALWAYS(a_idle_drained, !status.idle || !status.pipe_busy, "sequencer idle with taps in flight")
    // A word is never taken from an empty queue.
    `KLU_ASSERT_ALWAYS(a_pop_nonempty, !q_pop || q_has_data, "queue popped while empty")
    // A word that ends a line leaves the sequencer ready for a new step.
    `KLU_ASSERT_NEXT(a_eol_then_idle, out_valid && out_data.end_of_line && out_ready && $rose(out_valid), status.idle || !status.pipe_busy, "pipeline busy after line end")

endmodule
